### hdl/fmbq_pkg.sv
// ----------------------------------------------------------------------------
// fmbq_pkg
// Shared types and codes for the front/middle/back queue: word layouts,
// opcodes, status codes and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package fmbq_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  // fan-in of one reduction stage
  localparam int FAN     = 8;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_MID   = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_MID    = 3'd4;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] push_value;
  } fmbq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
  } fmbq_out_t;

  // per-cycle command shared by every cell of the row
  typedef struct packed {
    logic ins;  // open a slot at the position, shift the tail back
    logic rem;  // close the slot at the position, shift the tail forward
    logic rd;   // drive the entry at the position onto the read tap
  } fmbq_cell_ctrl_t;

endpackage

### hdl/front_middle_back_queue_core.sv
// ----------------------------------------------------------------------------
// front_middle_back_queue_core
// Bounded queue with push and pop at the front, the middle and the back,
// built as a row of cells that shift in parallel plus a registered read tree.
// ----------------------------------------------------------------------------
// Pipeline: LEVELS = ceil(log8(CAPACITY)) registered stages of the read tree
//   (2 at CAPACITY 64), then the output register.
// A new word is stalled until the current result enters the output register.
// The next word is taken while a finished result still waits at the output.
// Reset: asynchronous, active low; clears the count and the sequencer. Cell
//   contents are not cleared and are only read once written.
module front_middle_back_queue_core
  import fmbq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fmbq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fmbq_out_t out_data_o
);

  function automatic int tree_size(int n, int lvl);
    int m;
    m = n;
    for (int k = 0; k < lvl; k++) begin
      m = (m + FAN - 1) / FAN;
    end
    return m;
  endfunction

  function automatic int tree_levels(int n);
    int m;
    int l;
    m = n;
    l = 0;
    for (int k = 0; k < 8; k++) begin
      if (m > 1) begin
        m = (m + FAN - 1) / FAN;
        l = l + 1;
      end
    end
    return l;
  endfunction

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LEVELS = tree_levels(CAPACITY);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } fmbq_state_e;

  fmbq_state_e       state_q, state_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  fmbq_out_t         out_data_q;

  logic              empty_q;
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  cnt_res_q;

  logic              accept;
  logic              is_push;
  logic              is_pop;
  logic              full;
  logic              empty;
  logic [CNT_W-1:0]  pos_wide;
  logic [IDX_W-1:0]  pos;
  logic [STAT_W-1:0] status_d;
  fmbq_cell_ctrl_t   ctrl;
  logic              run_adv;
  logic              last_lvl;
  logic              out_load;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  wire [CAPACITY-1:0][DATA_W-1:0]        cell_val;
  wire [LEVELS:0][CAPACITY-1:0][DATA_W-1:0] tree;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // decode the operation and its position
  always_comb begin
    is_push  = (in_data_i.opcode == OP_PUSH_FRONT) || (in_data_i.opcode == OP_PUSH_MID) ||
               (in_data_i.opcode == OP_PUSH_BACK);
    is_pop   = (in_data_i.opcode == OP_POP_FRONT) || (in_data_i.opcode == OP_POP_MID) ||
               (in_data_i.opcode == OP_POP_BACK);
    full     = (count_q == CNT_W'(CAPACITY));
    empty    = (count_q == '0);
    case (in_data_i.opcode)
      OP_PUSH_MID:  pos_wide = count_q >> 1;
      OP_PUSH_BACK: pos_wide = count_q;
      OP_POP_MID:   pos_wide = (count_q - CNT_W'(1)) >> 1;
      OP_POP_BACK:  pos_wide = count_q - CNT_W'(1);
      default:      pos_wide = '0;
    endcase
    pos      = pos_wide[IDX_W-1:0];
    ctrl.ins = accept && is_push && !full;
    ctrl.rem = accept && is_pop && !empty;
    ctrl.rd  = is_pop && !empty;
    count_d  = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
    status_d = ST_OK;
    if (is_push && full) begin
      status_d = ST_FULL;
    end else if (is_pop && empty) begin
      status_d = ST_EMPTY;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = in_data_i.push_value;
    end else begin : g_mid
      assign prev_w = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = cell_val[i];
    end else begin : g_inner
      assign next_w = cell_val[i+1];
    end
    fmbq_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos),
      .push_i  (in_data_i.push_value),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .value_o (cell_val[i]),
      .tap_o   (tree[0][i])
    );
  end

  // registered read tree
  assign run_adv  = (state_q == S_RUN) && !last_lvl;
  assign last_lvl = (lvl_q == LVL_W'(LEVELS - 1));

  for (genvar k = 1; k <= LEVELS; k++) begin : g_tree
    localparam int NI = tree_size(CAPACITY, k - 1);
    localparam int NO = tree_size(CAPACITY, k);
    fmbq_or_stage #(
      .N_IN (NI)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   ((k == 1) ? accept : run_adv),
      .data_i (tree[k-1][NI-1:0]),
      .data_o (tree[k][NO-1:0])
    );
    if (NO < CAPACITY) begin : g_pad
      assign tree[k][CAPACITY-1:NO] = '0;
    end
  end

  // hold the result fields known at accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      empty_q   <= is_pop && empty;
      status_q  <= status_d;
      cnt_res_q <= count_d;
    end
  end

  // sequence the tree and hand over to the output register
  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          lvl_d   = '0;
        end
      end
      S_RUN: begin
        if (!last_lvl) begin
          lvl_d = lvl_q + LVL_W'(1);
        end else if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_res_q};

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.pop_value   <= empty_q ? '1 : tree[LEVELS][0];
      out_data_q.status      <= status_q;
      out_data_q.entry_count <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/fmbq_cell.sv
// ----------------------------------------------------------------------------
// fmbq_cell
// One queue slot. Holds one entry and, on an insert or remove, takes the word
// of its front-side or back-side neighbour, or the pushed word.
// ----------------------------------------------------------------------------
module fmbq_cell
  import fmbq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  logic                  clk_i,
  input  fmbq_cell_ctrl_t       ctrl_i,
  input  logic [IDX_W-1:0]      pos_i,
  input  logic [DATA_W-1:0]     push_i,
  input  logic [DATA_W-1:0]     prev_i,
  input  logic [DATA_W-1:0]     next_i,
  output logic [DATA_W-1:0]     value_o,
  output logic [DATA_W-1:0]     tap_o
);

  logic [DATA_W-1:0] value_q;
  logic [DATA_W-1:0] value_d;
  logic              at_pos;
  logic              past_pos;

  assign at_pos   = (IDX_W'(IDX) == pos_i);
  assign past_pos = (IDX_W'(IDX) > pos_i);

  // shift, load or hold
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (at_pos) begin
        value_d = push_i;
      end else if (past_pos) begin
        value_d = prev_i;
      end
    end else if (ctrl_i.rem) begin
      if (at_pos || past_pos) begin
        value_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // drive the read tap only from the addressed slot
  assign tap_o   = (ctrl_i.rd && at_pos) ? value_q : '0;

endmodule

### hdl/fmbq_or_stage.sv
// ----------------------------------------------------------------------------
// fmbq_or_stage
// One registered level of the read tree: ORs each group of FAN taps into one
// word. At most one tap of the row is ever non-zero.
// ----------------------------------------------------------------------------
module fmbq_or_stage
  import fmbq_pkg::*;
#(
  parameter int N_IN = 64
) (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  logic [N_IN-1:0][DATA_W-1:0]                data_i,
  output logic [((N_IN + FAN - 1) / FAN)-1:0][DATA_W-1:0] data_o
);

  localparam int N_OUT = (N_IN + FAN - 1) / FAN;

  logic [N_OUT-1:0][DATA_W-1:0] grp_d;

  // fold each group
  always_comb begin
    grp_d = '0;
    for (int j = 0; j < N_OUT; j++) begin
      for (int m = 0; m < FAN; m++) begin
        if (j * FAN + m < N_IN) begin
          grp_d[j] = grp_d[j] | data_i[j * FAN + m];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= grp_d;
    end
  end

endmodule

### hdl/fmbq_checker.sv
// ----------------------------------------------------------------------------
// fmbq_checker
// Port-level checks for the queue core, attached by bind.
// ----------------------------------------------------------------------------
module fmbq_checker
  import fmbq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input fmbq_out_t out_data_o
);

  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // take one word at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while one is in flight");

  // empty pop returns all ones
  a_empty_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |->
      (out_data_o.pop_value == '1) && (out_data_o.entry_count == '0))
    else $error("empty pop with wrong value or count");

  // dropped push reports a full queue
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |->
      (out_data_o.entry_count == CAP_CNT) && (out_data_o.pop_value == '0))
    else $error("full status with wrong count or value");

  // no undefined status code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK) || (out_data_o.status == ST_EMPTY) ||
      (out_data_o.status == ST_FULL))
    else $error("undefined status code");

endmodule

bind front_middle_back_queue_core fmbq_checker #(.CAPACITY(CAPACITY)) u_fmbq_checker (.*);
